// ===== rtl/core/sorted_double_ended_priority_queue_defines.svh =====
// Assertion macros shared by the sorted double-ended priority queue RTL.
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define SDEPQ_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SDEPQ_ASSERT_IMP(name, clk, rstn, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sdepq_pkg.sv =====
// Types and constants of the sorted double-ended priority queue.
`default_nettype none
package sdepq_pkg;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 16;
    localparam int CNT_W        = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_RMIN   = 2'd1;
    localparam logic [1:0] MODE_RMAX   = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } in_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     removed_key;
        logic [PAYLOAD_BITS-1:0] removed_payload;
        logic [KEY_BITS-1:0]     min_key;
        logic [PAYLOAD_BITS-1:0] min_payload;
        logic [KEY_BITS-1:0]     max_key;
        logic [PAYLOAD_BITS-1:0] max_payload;
        logic [CNT_W-1:0]        entry_total;
        logic [1:0]              status;
    } out_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic   ins;
        logic   rmin;
        logic   rmax;
        entry_t ent;
    } cmd_t;

    // Summary of the row seen by the control.
    typedef struct packed {
        logic   full;
        logic   empty;
        entry_t head;
        entry_t tail;
    } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdepq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`default_nettype none
module sdepq_cell
    import sdepq_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cmd_t   cmd_i,
    input  wire entry_t left_ent_i,
    input  wire logic   left_valid_i,
    input  wire logic   left_open_i,
    input  wire entry_t right_ent_i,
    input  wire logic   right_valid_i,
    output entry_t      ent_o,
    output logic        valid_o,
    output logic        open_o
);

    entry_t ent_reg, ent_next;
    logic   valid_reg, valid_next;

    // Slot takes a new key here or above: empty, or holding a strictly larger key
    assign open_o  = !valid_reg || (cmd_i.ent.key < ent_reg.key);
    assign ent_o   = ent_reg;
    assign valid_o = valid_reg;

    // Insert shifts right past the open point, remove-min shifts left, remove-max drops the tail
    always_comb begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (cmd_i.ins) begin
            if (left_open_i) begin
                ent_next = left_ent_i;
            end else if (open_o) begin
                ent_next = cmd_i.ent;
            end
            valid_next = valid_reg | left_valid_i;
        end else if (cmd_i.rmin) begin
            ent_next   = right_ent_i;
            valid_next = right_valid_i;
        end else if (cmd_i.rmax) begin
            valid_next = valid_reg & right_valid_i;
        end
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    // Hold the occupied flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sdepq_chain.sv =====
// Row of sorted cells with head and tail selection.
`default_nettype none
`include "sorted_double_ended_priority_queue_defines.svh"
module sdepq_chain
    import sdepq_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire cmd_t           cmd_i,
    output qstat_t              stat_o,
    output logic [CAPACITY-1:0] occ_o
);

    entry_t              ent_w   [CAPACITY];
    logic [CAPACITY-1:0] valid_w;
    logic [CAPACITY-1:0] open_w;
    logic [CAPACITY-1:0] tail_sel;
    entry_t              tail_ent;

    // Link each cell to its neighbors; the row ends see fixed boundary values
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t l_ent, r_ent;
        logic   l_valid, l_open, r_valid;

        if (i == 0) begin : g_first
            assign l_ent   = '0;
            assign l_valid = 1'b1;
            assign l_open  = 1'b0;
        end else begin : g_mid_l
            assign l_ent   = ent_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_open  = open_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_ent    = '0;
            assign r_valid  = 1'b0;
            assign tail_sel[i] = valid_w[i];
        end else begin : g_mid_r
            assign r_ent    = ent_w[i+1];
            assign r_valid  = valid_w[i+1];
            assign tail_sel[i] = valid_w[i] & ~valid_w[i+1];
        end

        sdepq_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd_i         (cmd_i),
            .left_ent_i    (l_ent),
            .left_valid_i  (l_valid),
            .left_open_i   (l_open),
            .right_ent_i   (r_ent),
            .right_valid_i (r_valid),
            .ent_o         (ent_w[i]),
            .valid_o       (valid_w[i]),
            .open_o        (open_w[i])
        );
    end

    // Pick the last occupied cell through a one-hot OR
    always_comb begin
        tail_ent = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tail_ent = tail_ent | (tail_sel[i] ? ent_w[i] : entry_t'('0));
        end
    end

    assign stat_o.full  = valid_w[CAPACITY-1];
    assign stat_o.empty = ~valid_w[0];
    assign stat_o.head  = ent_w[0];
    assign stat_o.tail  = tail_ent;
    assign occ_o        = valid_w;

    // Occupied cells form one run starting at slot zero
    for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
        `SDEPQ_ASSERT_IMP(a_contig, aclk, aresetn, valid_w[i], valid_w[i-1], "occupancy gap")
    end
    `SDEPQ_ASSERT(a_tail_1h0, aclk, aresetn, $onehot0(tail_sel), "several tails")
    `SDEPQ_ASSERT_IMP(a_tail_1h, aclk, aresetn, !stat_o.empty, $onehot(tail_sel),
        "no tail in a nonempty row")

endmodule
`default_nettype wire

// ===== rtl/core/sorted_double_ended_priority_queue.sv =====
// Top level of the sorted double-ended priority queue.
// Holds up to 16 (key, payload) entries in a row of cells kept in ascending key
// order; equal keys keep arrival order. Each beat on s_ inserts (mode 0), removes
// the minimum (1), removes the maximum (2) or queries (3), and yields exactly one
// beat on m_ with the removed entry, the new minimum and maximum, the entry count
// and a status (1: remove on empty, state kept; 2: insert on full, item dropped).
// One beat is taken every cycle while m_ready stays high. The result beat is
// built from the updated row once the output register is free, and goes valid
// on m_ from that register. With a result waiting on m_ and the next
// one pending, s_ready drops until m_ready returns. The cycle is set by the
// per-cell 32-bit key compare feeding the shift of every cell, and by the
// one-hot tail select of the row.
`default_nettype none
`include "sorted_double_ended_priority_queue_defines.svh"
module sorted_double_ended_priority_queue
    import sdepq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    cmd_t                cmd;
    qstat_t              stat;
    logic [CAPACITY-1:0] occ;

    logic             accept, out_free, out_load;
    logic             pend_reg, pend_next;
    entry_t           rem_reg, rem_next;
    logic [1:0]       st_reg, st_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = pend_reg && out_free;
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Decode the beat into a row command; drop it where it cannot apply
    always_comb begin
        cmd.ins  = accept && (s_data.mode == MODE_INSERT) && !stat.full;
        cmd.rmin = accept && (s_data.mode == MODE_RMIN) && !stat.empty;
        cmd.rmax = accept && (s_data.mode == MODE_RMAX) && !stat.empty;
        cmd.ent.key     = s_data.key;
        cmd.ent.payload = s_data.payload;
    end

    sdepq_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (cmd),
        .stat_o  (stat),
        .occ_o   (occ)
    );

    // Capture removed entry and status while the row updates
    always_comb begin
        rem_next   = rem_reg;
        st_next    = st_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        if (out_load) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            pend_next = 1'b1;
            rem_next  = '0;
            st_next   = ST_OK;
            case (s_data.mode)
                MODE_INSERT: begin
                    if (stat.full) begin
                        st_next = ST_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_RMIN: begin
                    if (stat.empty) begin
                        st_next = ST_EMPTY;
                    end else begin
                        rem_next   = stat.head;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_RMAX: begin
                    if (stat.empty) begin
                        st_next = ST_EMPTY;
                    end else begin
                        rem_next   = stat.tail;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Build the result from the updated row
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next                = 1'b1;
            m_data_next.removed_key     = rem_reg.key;
            m_data_next.removed_payload = rem_reg.payload;
            m_data_next.min_key         = stat.empty ? '0 : stat.head.key;
            m_data_next.min_payload     = stat.empty ? '0 : stat.head.payload;
            m_data_next.max_key         = stat.empty ? '0 : stat.tail.key;
            m_data_next.max_payload     = stat.empty ? '0 : stat.tail.payload;
            m_data_next.entry_total     = count_reg;
            m_data_next.status          = st_reg;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
    end

    // Hold control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SDEPQ_ASSERT(a_count, aclk, aresetn, $countones(occ) == 32'(count_reg),
        "count disagrees with occupied cells")
    `SDEPQ_ASSERT_IMP(a_full_st, aclk, aresetn,
        m_valid_reg && (m_data_reg.status == ST_FULL),
        m_data_reg.entry_total == CNT_W'(CAPACITY), "overflow reported below capacity")
    `SDEPQ_ASSERT_IMP(a_stall, aclk, aresetn, !s_ready, pend_reg && m_valid_reg,
        "input stalled without a backlog")

endmodule
`default_nettype wire
